/* sv/tsd_pkg.sv */
// shared types, constants and the crc-8 function of the thermometer scratchpad decoder
// no dependencies; used by tsd_ctrl, tsd_dp and the top level
package tsd_pkg;

    localparam int PAD_W      = 8;
    localparam int POS_W      = 4;
    localparam int TEMP_W     = 12;
    localparam int ALARM_W    = 8;
    localparam int STATUS_W   = 2;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 32;

    localparam logic [POS_W-1:0] POS_TEMP_LSB = 4'd0;
    localparam logic [POS_W-1:0] POS_TEMP_MSB = 4'd1;
    localparam logic [POS_W-1:0] POS_TH       = 4'd2;
    localparam logic [POS_W-1:0] POS_TL       = 4'd3;
    localparam logic [POS_W-1:0] POS_CREM     = 4'd6;
    localparam logic [POS_W-1:0] POS_CPD      = 4'd7;
    localparam logic [POS_W-1:0] POS_CHECK    = 4'd8;
    localparam logic [POS_W-1:0] POS_IDLE     = 4'd9;

    localparam logic [PAD_W-1:0] CRC_POLY = 8'h8C;

    localparam logic [STATUS_W-1:0] ST_GOOD    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_CRC_ERR = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_CPD  = 2'd2;

    // restoring divider by the count per degree, reciprocal scaling to tenths
    localparam int DIV_W     = 19;
    localparam int DIV_CNT_W = $clog2(DIV_W + 1);
    localparam int SCALED_W  = 18;
    localparam int MILLI_W   = 21;

    localparam logic [SCALED_W-1:0]      MILLI_PER_DEG = 18'd1000;
    localparam logic signed [MILLI_W-1:0] MILLI_PER_DEG_S = 21'sd1000;
    localparam logic signed [MILLI_W-1:0] HALF_STEP_MILLI = 21'sd250;

    // ceil(2^26 / 100), exact quotient by 100 for any 19-bit dividend
    localparam int RECIP_W     = 20;
    localparam int RECIP_SHIFT = 26;
    localparam int PROD_W      = DIV_W + RECIP_W;
    localparam logic [RECIP_W-1:0] TENTHS_RECIP = 20'd671089;

    localparam logic [TEMP_W-1:0] TEMP_MAX = 12'h7FF;
    localparam logic [TEMP_W-1:0] TEMP_MIN = 12'h800;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV1 = 4'b0010,
        S_DIV2 = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    typedef struct packed {
        logic take_byte;
        logic start_scale;
        logic start_tenths;
        logic finish_tenths;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic check_byte;
        logic frame_good;
        logic div_busy;
    } stat_t;

    function automatic logic [PAD_W-1:0] crc8_update(input logic [PAD_W-1:0] crc,
                                                     input logic [PAD_W-1:0] b);
        logic [PAD_W-1:0] c;
        c = crc ^ b;
        for (int k = 0; k < PAD_W; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

/* sv/tsd_ctrl.sv */
// controller of the thermometer scratchpad decoder: frame state machine and output valid
// depends on tsd_pkg; drives tsd_dp through cmd_t, reads stat_t
module tsd_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    input  tsd_pkg::stat_t stat,
    output tsd_pkg::cmd_t  cmd
);
    import tsd_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;
    logic   out_free;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        state_next       = state_reg;
        out_valid_next   = out_valid_reg;
        cmd              = '0;
        cmd.take_byte    = accept;
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE: begin
                if (accept && stat.check_byte) begin
                    if (stat.frame_good) begin
                        cmd.start_scale = 1'b1;
                        state_next      = S_DIV1;
                    end else begin
                        state_next = S_OUT;
                    end
                end
            end
            S_DIV1: begin
                if (!stat.div_busy) begin
                    cmd.start_tenths = 1'b1;
                    state_next       = S_DIV2;
                end
            end
            S_DIV2: begin
                cmd.finish_tenths = 1'b1;
                state_next        = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* sv/tsd_dp.sv */
// datapath of the thermometer scratchpad decoder: byte capture, crc-8, divider, output
// depends on tsd_pkg; commanded by tsd_ctrl
module tsd_dp (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              frame_start,
    input  logic [tsd_pkg::PAD_W-1:0]         pad_byte,
    input  tsd_pkg::cmd_t                     cmd,
    output tsd_pkg::stat_t                    stat,
    output logic signed [tsd_pkg::TEMP_W-1:0] temperature_tenths,
    output logic signed [tsd_pkg::ALARM_W-1:0] alarm_high,
    output logic signed [tsd_pkg::ALARM_W-1:0] alarm_low,
    output logic [tsd_pkg::STATUS_W-1:0]      status
);
    import tsd_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [PAD_W-1:0] crc_reg, crc_next;
    logic [PAD_W-1:0] temp_lsb_reg, temp_msb_reg, th_reg, tl_reg, crem_reg, cpd_reg;
    logic [STATUS_W-1:0] status_reg, status_next;

    logic [POS_W-1:0] pos_eff;
    logic [PAD_W-1:0] crc_eff;
    logic [PAD_W-1:0] crc_upd;

    // divider
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [PAD_W-1:0]     rem_reg, rem_next;
    logic [PAD_W-1:0]     dvs_reg, dvs_next;
    logic                 neg_reg, neg_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [PAD_W:0]       trial;
    logic                 trial_ge;
    logic [PROD_W-1:0]    tenths_prod;

    logic signed [MILLI_W-1:0] base_reg, base_next;
    logic signed [PAD_W:0]     diff;
    logic [PAD_W:0]            diff_abs;
    logic [SCALED_W-1:0]       scaled;
    logic signed [PAD_W-1:0]   whole_deg;
    logic signed [MILLI_W-1:0] frac_s;
    logic signed [MILLI_W-1:0] milli;
    logic [MILLI_W-1:0]        milli_abs;

    logic [TEMP_W-1:0]  t_sat;
    logic [ALARM_W-1:0] ah_dec, al_dec;

    logic [TEMP_W-1:0]   temp_out_reg;
    logic [ALARM_W-1:0]  ah_out_reg, al_out_reg;
    logic [STATUS_W-1:0] st_out_reg;

    assign pos_eff = frame_start ? '0 : pos_reg;
    assign crc_eff = frame_start ? '0 : crc_reg;
    assign crc_upd = crc8_update(crc_eff, pad_byte);

    assign stat.check_byte = (pos_eff == POS_CHECK);
    assign stat.frame_good = (crc_eff == pad_byte) && (cpd_reg != '0);
    assign stat.div_busy   = (cnt_reg != '0);

    // byte capture and crc
    always_comb begin
        pos_next    = pos_reg;
        crc_next    = crc_reg;
        status_next = status_reg;
        if (cmd.take_byte) begin
            if (pos_eff < POS_CHECK) begin
                pos_next = pos_eff + 4'd1;
                crc_next = crc_upd;
            end else if (pos_eff == POS_CHECK) begin
                pos_next = POS_IDLE;
                crc_next = crc_eff;
                priority if (crc_eff != pad_byte) begin
                    status_next = ST_CRC_ERR;
                end else if (cpd_reg == '0) begin
                    status_next = ST_NO_CPD;
                end else begin
                    status_next = ST_GOOD;
                end
            end else begin
                pos_next = pos_eff;
                crc_next = crc_eff;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            crc_reg      <= '0;
            temp_lsb_reg <= '0;
            temp_msb_reg <= '0;
            th_reg       <= '0;
            tl_reg       <= '0;
            crem_reg     <= '0;
            cpd_reg      <= '0;
            status_reg   <= ST_GOOD;
        end else begin
            pos_reg    <= pos_next;
            crc_reg    <= crc_next;
            status_reg <= status_next;
            if (cmd.take_byte) begin
                unique case (pos_eff)
                    POS_TEMP_LSB: temp_lsb_reg <= pad_byte;
                    POS_TEMP_MSB: temp_msb_reg <= pad_byte;
                    POS_TH:       th_reg       <= pad_byte;
                    POS_TL:       tl_reg       <= pad_byte;
                    POS_CREM:     crem_reg     <= pad_byte;
                    POS_CPD:      cpd_reg      <= pad_byte;
                    default: begin
                    end
                endcase
            end
        end
    end

    // operands of the division and the tenths scaling
    assign diff      = $signed({1'b0, cpd_reg}) - $signed({1'b0, crem_reg});
    assign diff_abs  = diff[PAD_W] ? 9'(-diff) : diff;
    assign scaled    = {{(SCALED_W-PAD_W){1'b0}}, diff_abs[PAD_W-1:0]} * MILLI_PER_DEG;
    assign whole_deg = $signed({temp_msb_reg[0], temp_lsb_reg[PAD_W-1:1]});
    assign frac_s    = neg_reg ? -$signed({{(MILLI_W-DIV_W){1'b0}}, quo_reg})
                               :  $signed({{(MILLI_W-DIV_W){1'b0}}, quo_reg});
    assign milli     = base_reg + frac_s;
    assign milli_abs = milli[MILLI_W-1] ? MILLI_W'(-milli) : milli;

    // quotient by 100 through the reciprocal
    assign tenths_prod = {{RECIP_W{1'b0}}, quo_reg} * {{DIV_W{1'b0}}, TENTHS_RECIP};

    // restoring divider, one quotient bit per cycle
    assign trial    = {rem_reg, quo_reg[DIV_W-1]};
    assign trial_ge = (trial >= {1'b0, dvs_reg});

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        base_next = base_reg;
        priority if (cmd.start_scale) begin
            quo_next  = {{(DIV_W-SCALED_W){1'b0}}, scaled};
            rem_next  = '0;
            dvs_next  = cpd_reg;
            neg_next  = diff[PAD_W];
            cnt_next  = DIV_CNT_W'(DIV_W);
            base_next = $signed({{(MILLI_W-PAD_W){whole_deg[PAD_W-1]}}, whole_deg})
                        * MILLI_PER_DEG_S - HALF_STEP_MILLI;
        end else if (cmd.start_tenths) begin
            quo_next = milli_abs[DIV_W-1:0];
            neg_next = milli[MILLI_W-1];
        end else if (cmd.finish_tenths) begin
            quo_next = {{(DIV_W-PROD_W+RECIP_SHIFT){1'b0}},
                        tenths_prod[PROD_W-1:RECIP_SHIFT]};
        end else if (cnt_reg != '0) begin
            rem_next = trial_ge ? 8'(trial - {1'b0, dvs_reg}) : trial[PAD_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], trial_ge};
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        neg_reg  <= neg_next;
        base_reg <= base_next;
    end

    // saturation and threshold decode
    always_comb begin
        if (!neg_reg) begin
            t_sat = (quo_reg > DIV_W'(TEMP_MAX)) ? TEMP_MAX : quo_reg[TEMP_W-1:0];
        end else begin
            t_sat = (quo_reg > DIV_W'(TEMP_MIN)) ? TEMP_MIN : TEMP_W'(-quo_reg[TEMP_W-1:0]);
        end
    end

    assign ah_dec = th_reg[ALARM_W-1] ? ALARM_W'(-{1'b0, th_reg[ALARM_W-2:0]})
                                      : {1'b0, th_reg[ALARM_W-2:0]};
    assign al_dec = tl_reg[ALARM_W-1] ? ALARM_W'(-{1'b0, tl_reg[ALARM_W-2:0]})
                                      : {1'b0, tl_reg[ALARM_W-2:0]};

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            st_out_reg <= status_reg;
            if (status_reg == ST_GOOD) begin
                temp_out_reg <= t_sat;
                ah_out_reg   <= ah_dec;
                al_out_reg   <= al_dec;
            end else begin
                temp_out_reg <= '0;
                ah_out_reg   <= '0;
                al_out_reg   <= '0;
            end
        end
    end

    assign temperature_tenths = $signed(temp_out_reg);
    assign alarm_high         = $signed(ah_out_reg);
    assign alarm_low          = $signed(al_out_reg);
    assign status             = st_out_reg;

endmodule

/* sv/thermometer_scratchpad_decoder_top.sv */
// top level of the thermometer scratchpad decoder
// depends on tsd_pkg, tsd_ctrl and tsd_dp
//
// Takes the nine scratchpad bytes one per transaction (s_tuser marks byte 0) and, after
// the check byte, returns one transaction with temperature in tenths of a degree, both
// alarm thresholds and a status (0 good, 1 crc mismatch, 2 zero count per degree).
// Bytes 0 to 7 are captured and folded into the crc. The check byte of a good frame runs a
// restoring divider by the count per degree, then scales the sum to tenths through a
// reciprocal multiply; its result is loaded in state S_OUT once the output register is
// free, and the next byte is taken in the cycle after that load at the earliest. A bad
// frame's result goes from the check byte straight to S_OUT and is loaded there the same way.
// Input is not taken during that work; a finished result waits in the output register
// without holding up further bytes until the next check byte finds it still waiting.
module thermometer_scratchpad_decoder_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [tsd_pkg::IN_DATA_W-1:0]     s_tdata,   // [7:0] pad_byte
    input  logic                              s_tuser,   // frame_start
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [11:0] temperature_tenths, [19:12] alarm_high, [27:20] alarm_low, [31:28] zero
    output logic [tsd_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic [tsd_pkg::STATUS_W-1:0]      m_tuser    // status
);
    import tsd_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    logic signed [TEMP_W-1:0]  temperature_tenths;
    logic signed [ALARM_W-1:0] alarm_high;
    logic signed [ALARM_W-1:0] alarm_low;
    logic [STATUS_W-1:0]       status;

    tsd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tsd_dp u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .frame_start        (s_tuser),
        .pad_byte           (s_tdata[PAD_W-1:0]),
        .cmd                (cmd),
        .stat               (stat),
        .temperature_tenths (temperature_tenths),
        .alarm_high         (alarm_high),
        .alarm_low          (alarm_low),
        .status             (status)
    );

    assign m_tdata = {{(OUT_DATA_W-TEMP_W-2*ALARM_W){1'b0}},
                      alarm_low, alarm_high, temperature_tenths};
    assign m_tuser = status;

endmodule
